[hdl/mrf_pkg.sv]
`timescale 1ns / 1ps

package mrf_pkg;

  localparam int unsigned HDR_LEN    = 1;
  localparam int unsigned PRESET_LEN = 6;
  localparam int unsigned FRAME_LEN  = PRESET_LEN + 2;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FN_READ_INPUT   = 8'h04;
  localparam logic [7:0]  FN_EXCEPTION    = 8'h80;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_REJECTED       = 2'd1,
    ST_COUNT_MISMATCH = 2'd2
  } status_e;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_VERDICT = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  slave;
    logic [7:0]  fn;
    logic [15:0] reg_addr;
    logic [15:0] voc;
    status_e     status;
    logic [6:0]  cnt;
    logic [15:0] val;
  } cmd_t;

endpackage

[hdl/mrf_front.sv]
`timescale 1ns / 1ps

module mrf_front #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              kind_i,
  input  logic [7:0]        function_code_i,
  input  logic [15:0]       reg_addr_i,
  input  logic [15:0]       value_or_count_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              rx_last_i,
  input  logic [7:0]        slave_addr_i,
  output logic              push_o,
  output mrf_pkg::cmd_t     cmd_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [15:0]      req_count_q, req_count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             addr_ok_q, addr_ok_d;
  logic [7:0]       fn_q, fn_d;
  logic [7:0]       byte_count_q, byte_count_d;
  logic [15:0]      first_word_q, first_word_d;

  logic             addr_ok_n;
  logic [7:0]       fn_n;
  logic [7:0]       byte_count_n;
  logic [15:0]      first_word_n;
  logic [6:0]       got;
  logic             is_read;

  always_comb begin
    addr_ok_n    = addr_ok_q;
    fn_n         = fn_q;
    byte_count_n = byte_count_q;
    first_word_n = first_word_q;
    if (idx_q == IDX_W'(0)) begin
      addr_ok_n = (rx_byte_i == slave_addr_i);
    end
    if (idx_q == IDX_W'(mrf_pkg::HDR_LEN)) begin
      fn_n = rx_byte_i;
    end
    if (idx_q == IDX_W'(mrf_pkg::HDR_LEN + 1)) begin
      byte_count_n = rx_byte_i;
    end
    if (idx_q == IDX_W'(mrf_pkg::HDR_LEN + 2)) begin
      first_word_n[15:8] = rx_byte_i;
    end
    if (idx_q == IDX_W'(mrf_pkg::HDR_LEN + 3)) begin
      first_word_n[7:0] = rx_byte_i;
    end
  end

  assign got     = byte_count_n[7:1];
  assign is_read = (fn_n == mrf_pkg::FN_READ_HOLDING) || (fn_n == mrf_pkg::FN_READ_INPUT);

  always_comb begin
    cmd_o          = '0;
    cmd_o.slave    = slave_addr_i;
    cmd_o.fn       = function_code_i;
    cmd_o.reg_addr = reg_addr_i;
    cmd_o.voc      = value_or_count_i;
    if (kind_i) begin
      cmd_o.kind     = mrf_pkg::CMD_VERDICT;
      cmd_o.slave    = '0;
      cmd_o.fn       = '0;
      cmd_o.reg_addr = '0;
      cmd_o.voc      = '0;
      priority if (!addr_ok_n || fn_n >= mrf_pkg::FN_EXCEPTION) begin
        cmd_o.status = mrf_pkg::ST_REJECTED;
      end else if (is_read) begin
        if ({9'd0, got} == req_count_q) begin
          cmd_o.status = mrf_pkg::ST_OK;
          cmd_o.cnt    = got;
          cmd_o.val    = first_word_n;
        end else begin
          cmd_o.status = mrf_pkg::ST_COUNT_MISMATCH;
        end
      end else begin
        cmd_o.status = mrf_pkg::ST_OK;
        cmd_o.cnt    = 7'd1;
        cmd_o.val    = first_word_n;
      end
    end else begin
      cmd_o.kind = mrf_pkg::CMD_REQUEST;
    end
  end

  assign push_o = accept_i && (!kind_i || rx_last_i);

  always_comb begin
    req_count_d  = req_count_q;
    idx_d        = idx_q;
    addr_ok_d    = addr_ok_q;
    fn_d         = fn_q;
    byte_count_d = byte_count_q;
    first_word_d = first_word_q;
    if (accept_i) begin
      if (!kind_i || rx_last_i) begin
        if (!kind_i) begin
          req_count_d = value_or_count_i;
        end
        idx_d        = '0;
        addr_ok_d    = 1'b0;
        fn_d         = '0;
        byte_count_d = '0;
        first_word_d = '0;
      end else begin
        addr_ok_d    = addr_ok_n;
        fn_d         = fn_n;
        byte_count_d = byte_count_n;
        first_word_d = first_word_n;
        if (idx_q != IDX_W'(MAX_FRAME_BYTES)) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_count_q  <= '0;
      idx_q        <= '0;
      addr_ok_q    <= 1'b0;
      fn_q         <= '0;
      byte_count_q <= '0;
      first_word_q <= '0;
    end else begin
      req_count_q  <= req_count_d;
      idx_q        <= idx_d;
      addr_ok_q    <= addr_ok_d;
      fn_q         <= fn_d;
      byte_count_q <= byte_count_d;
      first_word_q <= first_word_d;
    end
  end

endmodule

[hdl/mrf_fifo.sv]
`timescale 1ns / 1ps

module mrf_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrf_pkg::cmd_t data_i,
  input  logic          pop_i,
  output mrf_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mrf_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[hdl/mrf_back.sv]
`timescale 1ns / 1ps

module mrf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mrf_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_kind_o,
  output logic [7:0]    tx_byte_o,
  output logic          last_o,
  output logic [1:0]    status_o,
  output logic [6:0]    reg_count_o,
  output logic [15:0]   reg_value_o
);

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        valid_q, valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [1:0]  status_q, status_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] val_q, val_d;
  logic        adv, fire;
  logic [7:0]  tx;

  assign adv  = !valid_q || out_ready_i;
  assign fire = adv && !empty_i;

  always_comb begin
    unique case (idx_q)
      3'd0:    tx = cmd_i.slave;
      3'd1:    tx = cmd_i.fn;
      3'd2:    tx = cmd_i.reg_addr[15:8];
      3'd3:    tx = cmd_i.reg_addr[7:0];
      3'd4:    tx = cmd_i.voc[15:8];
      3'd5:    tx = cmd_i.voc[7:0];
      3'd6:    tx = crc_q[7:0];
      default: tx = crc_q[15:8];
    endcase
  end

  always_comb begin
    idx_d    = idx_q;
    crc_d    = crc_q;
    valid_d  = valid_q;
    kind_d   = kind_q;
    byte_d   = byte_q;
    last_d   = last_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    val_d    = val_q;
    pop_o    = 1'b0;
    if (adv) begin
      valid_d = 1'b0;
    end
    if (fire) begin
      valid_d = 1'b1;
      if (cmd_i.kind == mrf_pkg::CMD_VERDICT) begin
        kind_d   = 1'b1;
        byte_d   = '0;
        last_d   = 1'b1;
        status_d = cmd_i.status;
        cnt_d    = cmd_i.cnt;
        val_d    = cmd_i.val;
        pop_o    = 1'b1;
        idx_d    = '0;
        crc_d    = mrf_pkg::CRC_INIT;
      end else begin
        kind_d   = 1'b0;
        byte_d   = tx;
        last_d   = (idx_q == 3'(mrf_pkg::FRAME_LEN - 1));
        status_d = mrf_pkg::ST_OK;
        cnt_d    = '0;
        val_d    = '0;
        if (idx_q < 3'(mrf_pkg::PRESET_LEN)) begin
          crc_d = crc_byte(crc_q, tx);
        end
        if (idx_q == 3'(mrf_pkg::FRAME_LEN - 1)) begin
          pop_o = 1'b1;
          idx_d = '0;
          crc_d = mrf_pkg::CRC_INIT;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      crc_q   <= mrf_pkg::CRC_INIT;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
    status_q <= status_d;
    cnt_q    <= cnt_d;
    val_q    <= val_d;
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign tx_byte_o   = byte_q;
  assign last_o      = last_q;
  assign status_o    = status_q;
  assign reg_count_o = cnt_q;
  assign reg_value_o = val_q;

endmodule

[hdl/modbus_rtu_master_framer_core.sv]
`timescale 1ns / 1ps
// Channel  | Handshake            | Word
// in       | in_valid/in_ready    | kind, function_code, reg_addr, value_or_count, rx_byte, rx_last
// out      | out_valid/out_ready  | out_kind, tx_byte, last, status, reg_count, reg_value
// cfg      | APB psel/penable     | slave_address at 0x0
// One input word per cycle while the command queue (QUEUE_DEPTH) has room.
// A request gives 8 out words from the byte sequencer; CRC one byte a cycle unless out stalls.
// The last response byte pushes its verdict into the queue as it is accepted.
// Reset clears all control state and sets slave_address to 1; no clearing pass.
// Out stalls fill the queue, then drop in_ready.

module modbus_rtu_master_framer_core #(
  parameter int unsigned MAX_FRAME_BYTES = 256,
  parameter int unsigned QUEUE_DEPTH     = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] reg_addr_i,
  input  logic [15:0] value_or_count_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [6:0]  reg_count_o,
  output logic [15:0] reg_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]    slave_q, slave_d;
  logic          accept;
  logic          push, pop, full, empty;
  mrf_pkg::cmd_t push_cmd, head_cmd;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, slave_q};

  always_comb begin
    slave_d = slave_q;
    if (psel && penable && pwrite && pready && !paddr[2]) begin
      slave_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= mrf_pkg::SLAVE_ADDR_RESET;
    end else begin
      slave_q <= slave_d;
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  mrf_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .kind_i          (kind_i),
    .function_code_i (function_code_i),
    .reg_addr_i      (reg_addr_i),
    .value_or_count_i(value_or_count_i),
    .rx_byte_i       (rx_byte_i),
    .rx_last_i       (rx_last_i),
    .slave_addr_i    (slave_q),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  mrf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  mrf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_kind_o (out_kind_o),
    .tx_byte_o  (tx_byte_o),
    .last_o     (last_o),
    .status_o   (status_o),
    .reg_count_o(reg_count_o),
    .reg_value_o(reg_value_o)
  );

endmodule

[hdl/mrf_checker.sv]
`timescale 1ns / 1ps

module mrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        out_kind_o,
  input logic [7:0]  tx_byte_o,
  input logic        last_o,
  input logic [1:0]  status_o,
  input logic [6:0]  reg_count_o,
  input logic [15:0] reg_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o) && $stable(last_o)
      && $stable(out_kind_o) && $stable(status_o) && $stable(reg_value_o))
    else $error("out word changed while stalled");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_kind_o |-> status_o == 2'd0 && reg_count_o == 7'd0
      && reg_value_o == 16'd0)
    else $error("frame byte carries verdict fields");

  a_verdict_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o |-> last_o && tx_byte_o == 8'd0 && status_o != 2'd3)
    else $error("malformed verdict");

  a_bad_verdict_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o && status_o != 2'd0 |-> reg_count_o == 7'd0
      && reg_value_o == 16'd0)
    else $error("failed verdict carries data");

endmodule

bind modbus_rtu_master_framer_core mrf_checker u_mrf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_kind_o (out_kind_o),
  .tx_byte_o  (tx_byte_o),
  .last_o     (last_o),
  .status_o   (status_o),
  .reg_count_o(reg_count_o),
  .reg_value_o(reg_value_o)
);

[verif/tb_modbus_rtu_master_framer_core.sv]
`timescale 1ns / 1ps

module tb_modbus_rtu_master_framer_core;

  localparam int unsigned    MAX_FRAME_BYTES = 256;
  localparam int             ITEMS_PER_PHASE = 36;
  localparam int             DRAIN_PAD       = 16;
  localparam logic [2:0]     REG_SLAVE_ADDR  = 3'd0;
  localparam logic [7:0]     FN_WRITE_SINGLE = 8'h06;

  typedef struct {
    mrf_pkg::cmd_kind_e kind;
    logic [7:0]         fn;
    logic [15:0]        reg_addr;
    logic [15:0]        voc;
    logic [7:0]         rx_byte;
    logic               rx_last;
  } in_word_t;

  typedef struct {
    mrf_pkg::cmd_kind_e out_kind;
    logic [7:0]         tx_byte;
    logic               last;
    mrf_pkg::status_e   status;
    logic [6:0]         reg_count;
    logic [15:0]        reg_value;
  } out_word_t;

  class framer_scoreboard;
    logic [7:0]  slave_addr;
    logic [15:0] requested_count;
    int unsigned rx_index;
    bit          rx_addr_ok;
    logic [7:0]  rx_function;
    logic [7:0]  rx_byte_count;
    logic [15:0] rx_first_word;
    out_word_t   due_words[$];
    int          errors;

    function new();
      slave_addr      = mrf_pkg::SLAVE_ADDR_RESET;
      requested_count = '0;
      errors          = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      rx_index      = 0;
      rx_addr_ok    = 1'b0;
      rx_function   = '0;
      rx_byte_count = '0;
      rx_first_word = '0;
    endfunction

    function void frame_request(in_word_t w);
      logic [7:0]  frame[mrf_pkg::FRAME_LEN];
      logic [15:0] crc;
      out_word_t   o;
      frame[0] = slave_addr;
      frame[1] = w.fn;
      frame[2] = w.reg_addr[15:8];
      frame[3] = w.reg_addr[7:0];
      frame[4] = w.voc[15:8];
      frame[5] = w.voc[7:0];
      crc = mrf_pkg::CRC_INIT;
      for (int i = 0; i < mrf_pkg::PRESET_LEN; i++) begin
        crc ^= {8'h00, frame[i]};
        for (int k = 0; k < 8; k++)
          crc = crc[0] ? ((crc >> 1) ^ mrf_pkg::CRC_POLY) : (crc >> 1);
      end
      frame[mrf_pkg::PRESET_LEN]     = crc[7:0];
      frame[mrf_pkg::PRESET_LEN + 1] = crc[15:8];
      requested_count = w.voc;
      clear_capture();
      for (int i = 0; i < mrf_pkg::FRAME_LEN; i++) begin
        o.out_kind  = mrf_pkg::CMD_REQUEST;
        o.tx_byte   = frame[i];
        o.last      = (i == mrf_pkg::FRAME_LEN - 1);
        o.status    = mrf_pkg::ST_OK;
        o.reg_count = '0;
        o.reg_value = '0;
        due_words.push_back(o);
      end
    endfunction

    function void judge_reply(in_word_t w);
      out_word_t  o;
      logic [7:0] got_count;
      case (rx_index)
        0:                    rx_addr_ok = (w.rx_byte == slave_addr);
        mrf_pkg::HDR_LEN:     rx_function = w.rx_byte;
        mrf_pkg::HDR_LEN + 1: rx_byte_count = w.rx_byte;
        mrf_pkg::HDR_LEN + 2: rx_first_word[15:8] = w.rx_byte;
        mrf_pkg::HDR_LEN + 3: rx_first_word[7:0] = w.rx_byte;
        default: ;
      endcase
      if (rx_index < MAX_FRAME_BYTES)
        rx_index++;
      if (!w.rx_last)
        return;
      o.out_kind  = mrf_pkg::CMD_VERDICT;
      o.tx_byte   = '0;
      o.last      = 1'b1;
      o.status    = mrf_pkg::ST_OK;
      o.reg_count = '0;
      o.reg_value = '0;
      got_count   = rx_byte_count >> 1;
      if (!rx_addr_ok || rx_function >= mrf_pkg::FN_EXCEPTION) begin
        o.status = mrf_pkg::ST_REJECTED;
      end else if (rx_function == mrf_pkg::FN_READ_HOLDING
                   || rx_function == mrf_pkg::FN_READ_INPUT) begin
        if ({8'h00, got_count} == requested_count) begin
          o.reg_count = got_count[6:0];
          o.reg_value = rx_first_word;
        end else begin
          o.status = mrf_pkg::ST_COUNT_MISMATCH;
        end
      end else begin
        o.reg_count = 7'd1;
        o.reg_value = rx_first_word;
      end
      due_words.push_back(o);
      clear_capture();
    endfunction

    function void note_word(in_word_t w);
      if (w.kind == mrf_pkg::CMD_REQUEST)
        frame_request(w);
      else
        judge_reply(w);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected word: expected none, got %p", $time, got);
        return;
      end
      want = due_words.pop_front();
      check_field("out_kind", 16'(want.out_kind), 16'(got.out_kind));
      check_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
      check_field("last", 16'(want.last), 16'(got.last));
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("reg_count", 16'(want.reg_count), 16'(got.reg_count));
      check_field("reg_value", want.reg_value, got.reg_value);
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic        kind_i           = 1'b0;
  logic [7:0]  function_code_i  = '0;
  logic [15:0] reg_addr_i       = '0;
  logic [15:0] value_or_count_i = '0;
  logic [7:0]  rx_byte_i        = '0;
  logic        rx_last_i        = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic        out_kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic [6:0]  reg_count_o;
  logic [15:0] reg_value_o;
  logic        psel             = 1'b0;
  logic        penable          = 1'b0;
  logic        pwrite           = 1'b0;
  logic [2:0]  paddr            = '0;
  logic [31:0] pwdata           = '0;
  logic [31:0] prdata;
  logic        pready;

  framer_scoreboard frames;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;

  modbus_rtu_master_framer_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .function_code_i  (function_code_i),
    .reg_addr_i       (reg_addr_i),
    .value_or_count_i (value_or_count_i),
    .rx_byte_i        (rx_byte_i),
    .rx_last_i        (rx_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_kind_o       (out_kind_o),
    .tx_byte_o        (tx_byte_o),
    .last_o           (last_o),
    .status_o         (status_o),
    .reg_count_o      (reg_count_o),
    .reg_value_o      (reg_value_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    out_word_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.out_kind  = mrf_pkg::cmd_kind_e'(out_kind_o);
      r.tx_byte   = tx_byte_o;
      r.last      = last_o;
      r.status    = mrf_pkg::status_e'(status_o);
      r.reg_count = reg_count_o;
      r.reg_value = reg_value_o;
      frames.check_word(r);
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= w.kind;
    function_code_i  <= w.fn;
    reg_addr_i       <= w.reg_addr;
    value_or_count_i <= w.voc;
    rx_byte_i        <= w.rx_byte;
    rx_last_i        <= w.rx_last;
    do @(posedge clk_i); while (!in_ready_o);
    frames.note_word(w);
    items_sent++;
  endtask

  task automatic send_request(logic [7:0] fn, logic [15:0] addr, logic [15:0] voc);
    in_word_t w;
    w.kind     = mrf_pkg::CMD_REQUEST;
    w.fn       = fn;
    w.reg_addr = addr;
    w.voc      = voc;
    w.rx_byte  = $urandom_range(255);
    w.rx_last  = $urandom_range(1);
    send_word(w);
  endtask

  task automatic send_reply(logic [7:0] seq[$], bit mark_last);
    in_word_t w;
    foreach (seq[i]) begin
      w.kind     = mrf_pkg::CMD_VERDICT;
      w.fn       = $urandom_range(255);
      w.reg_addr = $urandom_range(65535);
      w.voc      = $urandom_range(65535);
      w.rx_byte  = seq[i];
      w.rx_last  = mark_last && (i == seq.size() - 1);
      send_word(w);
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (frames.due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic write_slave(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SLAVE_ADDR;
    pwdata  <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frames.slave_addr = v;
  endtask

  task automatic directed_checks();
    logic [7:0] r[$];
    // verdict with no request yet
    r = '{8'h01};
    send_reply(r, 1'b1);
    send_request(mrf_pkg::FN_READ_HOLDING, 16'h0000, 16'h0002);
    r = '{8'h01, mrf_pkg::FN_READ_HOLDING, 8'h04, 8'hAB, 8'hCD, 8'h12, 8'h34, 8'h5A, 8'hA5};
    send_reply(r, 1'b1);
    send_request(mrf_pkg::FN_READ_INPUT, 16'hFFFF, 16'hFFFF);
    r = '{8'h01, mrf_pkg::FN_READ_INPUT, 8'hFE, 8'h11, 8'h22};
    send_reply(r, 1'b1);
    send_request(FN_WRITE_SINGLE, 16'h1234, 16'h0000);
    r = '{8'h01, FN_WRITE_SINGLE, 8'h12, 8'h34, 8'h00, 8'h00, 8'hFF, 8'h00};
    send_reply(r, 1'b1);
    send_request(8'h00, 16'h5555, 16'hAAAA);
    send_request(8'hFF, 16'hAAAA, 16'h5555);
    r = '{8'h01, mrf_pkg::FN_EXCEPTION, 8'h02};
    send_reply(r, 1'b1);
    r = '{8'h01, 8'h7F, 8'h00, 8'hFF, 8'hFF};
    send_reply(r, 1'b1);
    r = '{8'h02, mrf_pkg::FN_READ_HOLDING, 8'h02};
    send_reply(r, 1'b1);
    // short reply, byte count never arrives
    r = '{8'h01, mrf_pkg::FN_READ_HOLDING};
    send_reply(r, 1'b1);
    // partial reply cut off by a new request
    send_request(mrf_pkg::FN_READ_HOLDING, 16'h0000, 16'h0001);
    r = '{8'h01, mrf_pkg::FN_READ_HOLDING, 8'h02};
    send_reply(r, 1'b0);
    send_request(mrf_pkg::FN_READ_HOLDING, 16'h0100, 16'h0001);
    // long reply, trailing bytes only counted
    r = '{8'h01, mrf_pkg::FN_READ_HOLDING, 8'h02, 8'hBE, 8'hEF};
    repeat (12) r.push_back($urandom_range(255));
    send_reply(r, 1'b1);
  endtask

  task automatic random_exchange();
    logic [7:0]  fn;
    logic [7:0]  bc;
    logic [15:0] cnt;
    logic [7:0]  r[$];
    int          pick;
    int          n;
    in_word_t    w;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3: fn = mrf_pkg::FN_READ_HOLDING;
      4, 5, 6:    fn = mrf_pkg::FN_READ_INPUT;
      7, 8:       fn = FN_WRITE_SINGLE;
      default:    fn = $urandom_range(255);
    endcase
    case ($urandom_range(19))
      0:       cnt = $urandom_range(65535);
      1:       cnt = $urandom_range(127);
      default: cnt = $urandom_range(4);
    endcase
    if (pick < 90)
      send_request(fn, $urandom_range(65535), cnt);
    if (pick < 80) begin
      r.push_back(($urandom_range(19) == 0) ?
                  frames.slave_addr ^ 8'($urandom_range(254) + 1) : frames.slave_addr);
      r.push_back(($urandom_range(14) == 0) ? (fn | mrf_pkg::FN_EXCEPTION) : fn);
      if (fn == mrf_pkg::FN_READ_HOLDING || fn == mrf_pkg::FN_READ_INPUT) begin
        bc = ($urandom_range(9) == 0 || cnt > 127) ? 8'($urandom_range(255)) : 8'(cnt * 2);
        r.push_back(bc);
        n = (bc <= 8) ? bc : 4;
      end else begin
        n = 4;
      end
      repeat (n + 2) r.push_back($urandom_range(255));
      if (pick >= 70)
        r = r[0:$urandom_range(4)];
      send_reply(r, 1'b1);
    end else if (pick < 90) begin
      r.push_back(frames.slave_addr);
      repeat ($urandom_range(3)) r.push_back($urandom_range(255));
      send_reply(r, 1'b0);
    end else begin
      repeat ($urandom_range(6, 1)) begin
        w.kind     = mrf_pkg::cmd_kind_e'($urandom_range(1));
        w.fn       = $urandom_range(255);
        w.reg_addr = $urandom_range(65535);
        w.voc      = $urandom_range(65535);
        w.rx_byte  = $urandom_range(255);
        w.rx_last  = $urandom_range(1);
        send_word(w);
      end
    end
    if ($urandom_range(24) == 0)
      quiesce();
  endtask

  initial begin
    frames = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_checks();
    quiesce();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;  stall_pct = 0;  write_slave(8'h00);
        end
        1: begin
          idle_pct = 45; stall_pct = 0;  write_slave(8'hFF);
        end
        2: begin
          idle_pct = 0;  stall_pct = 45; write_slave(8'($urandom_range(254, 1)));
        end
        default: begin
          idle_pct = 34; stall_pct = 34; write_slave(8'($urandom_range(255)));
        end
      endcase
      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) random_exchange();
      quiesce();
    end
    if (frames.errors == 0 && frames.due_words.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
